/* rtl/core/capped_backoff_restart_tracker_unit_defines.svh */
// assertion macros for the capped backoff restart tracker
`ifndef CAPPED_BACKOFF_RESTART_TRACKER_UNIT_DEFINES_SVH
`define CAPPED_BACKOFF_RESTART_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define CBRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbrt assertion failed");

// condition holds in the following cycle
`define CBRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbrt assertion failed");

`else

`define CBRT_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/cbrt_pkg.sv */
// shared types and constants of the capped backoff restart tracker
`timescale 1ns / 1ps
`default_nettype none

package cbrt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [TIME_W-1:0] INITIAL_RESET   = 32'd1000;
  localparam logic [TIME_W-1:0] MAXIMUM_RESET   = 32'd30000;
  localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 8'd3;
  localparam logic [CNT_W-1:0]  FAIL_MAX        = 8'd255;

  typedef enum logic [1:0] {
    MODE_QUERY   = 2'd0,
    MODE_START   = 2'd1,
    MODE_CAPTURE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_INITIAL   = 2'd0,
    REG_MAXIMUM   = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [TIME_W-1:0] eff_initial;
    logic [TIME_W-1:0] eff_maximum;
    logic [CNT_W-1:0]  eff_threshold;
  } cfg_t;

  // delay reload request on a register write
  typedef struct packed {
    logic              reload;
    logic [TIME_W-1:0] initial_delay;
  } cfg_upd_t;

endpackage

`default_nettype wire

/* rtl/core/cbrt_in_if.sv */
// input event channel
`timescale 1ns / 1ps
`default_nettype none

interface cbrt_in_if;
  import cbrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic              success;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, mode, success, now_time, input ready);
  modport sink (input valid, mode, success, now_time, output ready);
endinterface

`default_nettype wire

/* rtl/core/cbrt_out_if.sv */
// result channel
`timescale 1ns / 1ps
`default_nettype none

interface cbrt_out_if;
  import cbrt_pkg::*;

  logic              valid;
  logic              ready;
  logic              restart_needed;
  logic              start_is_due;
  logic              is_running;
  logic [TIME_W-1:0] current_delay;
  logic [TIME_W-1:0] next_start_time;

  modport source (output valid, restart_needed, start_is_due, is_running,
                  current_delay, next_start_time, input ready);
  modport sink (input valid, restart_needed, start_is_due, is_running,
                current_delay, next_start_time, output ready);
endinterface

`default_nettype wire

/* rtl/core/capped_backoff_restart_tracker_unit.sv */
// Capped backoff restart tracker, top level.
// Path: input transaction to result valid goes through the input register,
// then the result register; the combinational state update sits between.
// Throughput: one transaction per cycle unless out_ch back-pressure stalls it.
// Reset (synchronous): not running, failure count 0, delay 1000, next start 0,
// registers back to their defaults, both pipeline slots empty.
`include "capped_backoff_restart_tracker_unit_defines.svh"
`timescale 1ns / 1ps
`default_nettype none

module capped_backoff_restart_tracker_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  cbrt_in_if.sink                           in_ch,
  cbrt_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cbrt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cbrt_pkg::DATA_W-1:0]  pwdata,
  output logic      [cbrt_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import cbrt_pkg::*;

  cfg_t     cfg;
  cfg_upd_t upd;

  cbrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .upd     (upd)
  );

  // input register
  logic              in_valid;
  logic [1:0]        in_mode;
  logic              in_success;
  logic [TIME_W-1:0] in_now;

  // tracker state
  logic              running_flag, running_next;
  logic [CNT_W-1:0]  failure_count, failure_count_next;
  logic [TIME_W-1:0] retry_delay, retry_delay_next;
  logic [TIME_W-1:0] next_start, next_start_next;

  logic              restart;
  logic              backoff;
  logic              fire;
  logic [CNT_W-1:0]  cnt_inc;
  logic [TIME_W:0]   twice;
  logic [TIME_W-1:0] diff;
  logic              due;

  assign fire        = in_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid || fire;

  // saturating failure count
  assign cnt_inc = (failure_count == FAIL_MAX) ? failure_count : failure_count + CNT_W'(1);

  // event decode
  always_comb begin
    running_next       = running_flag;
    failure_count_next = failure_count;
    retry_delay_next   = retry_delay;
    restart            = 1'b0;
    backoff            = 1'b0;
    unique case (mode_e'(in_mode))
      MODE_START: begin
        running_next       = in_success;
        failure_count_next = '0;
        if (in_success) begin
          retry_delay_next = cfg.eff_initial;
        end else begin
          backoff = 1'b1;
        end
      end
      MODE_CAPTURE: begin
        if (running_flag) begin
          if (in_success) begin
            failure_count_next = '0;
            retry_delay_next   = cfg.eff_initial;
          end else if (cnt_inc >= cfg.eff_threshold) begin
            running_next       = 1'b0;
            failure_count_next = '0;
            backoff            = 1'b1;
            restart            = 1'b1;
          end else begin
            failure_count_next = cnt_inc;
          end
        end
      end
      default: begin
        running_next = running_flag;
      end
    endcase

    // schedule retry and grow delay up to the cap
    twice           = {retry_delay, 1'b0};
    next_start_next = next_start;
    if (backoff) begin
      next_start_next = in_now + retry_delay;
      if (retry_delay < cfg.eff_maximum) begin
        retry_delay_next = (twice > {1'b0, cfg.eff_maximum}) ? cfg.eff_maximum
                                                             : twice[TIME_W-1:0];
      end
    end
  end

  // wrap-safe due test on the updated schedule
  assign diff = in_now - next_start_next;
  assign due  = !running_next && !diff[TIME_W-1];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_ch.valid  <= 1'b0;
      running_flag  <= 1'b0;
      failure_count <= '0;
      retry_delay   <= INITIAL_RESET;
      next_start    <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (fire) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (upd.reload) begin
        retry_delay <= upd.initial_delay;
      end else if (fire) begin
        retry_delay <= retry_delay_next;
      end
      if (fire) begin
        running_flag  <= running_next;
        failure_count <= failure_count_next;
        next_start    <= next_start_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mode    <= in_ch.mode;
      in_success <= in_ch.success;
      in_now     <= in_ch.now_time;
    end
    if (fire) begin
      out_ch.restart_needed  <= restart;
      out_ch.start_is_due    <= due;
      out_ch.is_running      <= running_next;
      out_ch.current_delay   <= retry_delay_next;
      out_ch.next_start_time <= next_start_next;
    end
  end

  // checks
  `CBRT_ASSERT_SAME(a_due_not_running, clk, rst, out_ch.valid, !(out_ch.is_running && out_ch.start_is_due))
  `CBRT_ASSERT_SAME(a_restart_stops, clk, rst, out_ch.valid && out_ch.restart_needed, !out_ch.is_running)
  `CBRT_ASSERT_SAME(a_delay_nonzero, clk, rst, 1'b1, retry_delay != '0)
  `CBRT_ASSERT_NEXT(a_delay_capped, clk, rst, fire, retry_delay <= cfg.eff_maximum)

endmodule

`default_nettype wire

/* rtl/core/cbrt_cfg.sv */
// apb register file with clamped effective configuration
`timescale 1ns / 1ps
`default_nettype none

module cbrt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbrt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cbrt_pkg::DATA_W-1:0]   pwdata,
  output logic      [cbrt_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output cbrt_pkg::cfg_t                     cfg,
  output cbrt_pkg::cfg_upd_t                 upd
);
  import cbrt_pkg::*;

  logic [TIME_W-1:0] initial_delay, initial_delay_next;
  logic [TIME_W-1:0] maximum_delay, maximum_delay_next;
  logic [CNT_W-1:0]  failure_threshold, failure_threshold_next;
  logic [TIME_W-1:0] eff_init_next;
  logic              wr;
  logic              wr_hit;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  // register write decode
  always_comb begin
    initial_delay_next     = initial_delay;
    maximum_delay_next     = maximum_delay;
    failure_threshold_next = failure_threshold;
    wr_hit                 = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_INITIAL: begin
          initial_delay_next = pwdata[TIME_W-1:0];
          wr_hit             = 1'b1;
        end
        REG_MAXIMUM: begin
          maximum_delay_next = pwdata[TIME_W-1:0];
          wr_hit             = 1'b1;
        end
        REG_THRESHOLD: begin
          failure_threshold_next = pwdata[CNT_W-1:0];
          wr_hit                 = 1'b1;
        end
        default: wr_hit = 1'b0;
      endcase
    end
  end

  // zero initial delay acts as one
  assign eff_init_next = (initial_delay_next == '0) ? TIME_W'(1) : initial_delay_next;

  assign upd.reload        = wr_hit;
  assign upd.initial_delay = eff_init_next;

  // raw and clamped register state
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay     <= INITIAL_RESET;
      maximum_delay     <= MAXIMUM_RESET;
      failure_threshold <= THRESHOLD_RESET;
      cfg.eff_initial   <= INITIAL_RESET;
      cfg.eff_maximum   <= MAXIMUM_RESET;
      cfg.eff_threshold <= THRESHOLD_RESET;
    end else begin
      initial_delay     <= initial_delay_next;
      maximum_delay     <= maximum_delay_next;
      failure_threshold <= failure_threshold_next;
      cfg.eff_initial   <= eff_init_next;
      cfg.eff_maximum   <= (maximum_delay_next < eff_init_next) ? eff_init_next
                                                                : maximum_delay_next;
      cfg.eff_threshold <= (failure_threshold_next == '0) ? CNT_W'(1)
                                                          : failure_threshold_next;
    end
  end

  // read back raw values
  always_comb begin
    unique case (idx)
      REG_INITIAL:   prdata = DATA_W'(initial_delay);
      REG_MAXIMUM:   prdata = DATA_W'(maximum_delay);
      REG_THRESHOLD: prdata = DATA_W'(failure_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
